// ----- hdl/assert_macros.svh -----
// assertion macros for the notch crossing rtl
// needs clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed: same cycle");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed: next cycle");

`endif

// ----- hdl/bnc_pkg.sv -----
// types and constants for the bond notch crossing test
// used by bnc_prep, bnc_cell and the top level
package bnc_pkg;

    localparam int NUM_POSITIONS = 4;
    localparam int MAX_SAMPLES   = 16;
    localparam int COORD_WIDTH   = 16;
    localparam int SAMP_W        = 5;
    localparam int CNT_W         = 3;
    localparam int SCALED_W      = 22;

    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_TARGET    = 3'd1,
        REG_BAND_LOW  = 3'd2,
        REG_BAND_HIGH = 3'd3,
        REG_WIDTH     = 3'd4,
        REG_SAMPLES   = 3'd5,
        REG_POS_COUNT = 3'd6,
        REG_POSITIONS = 3'd7
    } cfg_addr_t;

    typedef struct packed {
        logic                                 mode;
        logic [7:0]                           target;
        logic signed [COORD_WIDTH-1:0]        band_low;
        logic signed [COORD_WIDTH-1:0]        band_high;
        logic [COORD_WIDTH-1:0]               slot_width;
        logic [SAMP_W-1:0]                    sample_count;
        logic [CNT_W-1:0]                     position_count;
        logic [NUM_POSITIONS*COORD_WIDTH-1:0] positions;
    } cfg_t;

    // one bond as it moves down the cell chain
    typedef struct packed {
        logic [15:0]                   node_index;
        logic [5:0]                    neighbor_slot;
        logic                          gate;
        logic [SAMP_W-1:0]             n;
        logic signed [COORD_WIDTH-1:0] x0;
        logic signed [COORD_WIDTH-1:0] y0;
        logic signed [COORD_WIDTH-1:0] x1;
        logic signed [COORD_WIDTH-1:0] y1;
        logic signed [SCALED_W-1:0]    x0n;
        logic signed [SCALED_W-1:0]    y0n;
        logic signed [SCALED_W-1:0]    bln;
        logic signed [SCALED_W-1:0]    bhn;
        logic                          hit;
    } item_t;

endpackage

// ----- hdl/bond_notch_crossing_test.sv -----
// top level of the bond notch crossing test: config registers, cell chain, output register
// depends on bnc_pkg, bnc_prep, bnc_cell and assert_macros.svh
//
//   channel   handshake              payload
//   in        in_valid / in_stall    node_index .. end_y
//   out       out_valid / out_stall  out_node_index, out_neighbor_slot, break_bond
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a bond passes a prep stage and four position cells, each registered, then the output register
// out_valid rises once the bond has passed the prep register, the four cell registers and the
// output register; one bond is in flight at a time, so a new bond is taken only after the result
// transaction of the last one completes, and output stalls hold the next bond back further
// in_stall rises after acceptance and stays high until the result transaction completes
// reset clears the config registers to zero and empties the chain
`include "assert_macros.svh"

module bond_notch_crossing_test (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        node_index,
    input  logic [5:0]         neighbor_slot,
    input  logic [7:0]         node_particle,
    input  logic [7:0]         neighbor_particle,
    input  logic               neighbor_valid,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic signed [15:0] end_x,
    input  logic signed [15:0] end_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        out_node_index,
    output logic [5:0]         out_neighbor_slot,
    output logic               break_bond,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import bnc_pkg::*;

    cfg_t               cfg_reg;
    logic               busy_reg;
    logic               busy_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [15:0]        out_index_reg;
    logic [5:0]         out_slot_reg;
    logic               out_hit_reg;
    logic               accept;
    logic               deliver;
    logic [CNT_W-1:0]   pos_count;
    logic [NUM_POSITIONS:0] chain_valid;
    item_t              chain_item [0:NUM_POSITIONS];

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !busy_reg;
    assign deliver   = out_valid_reg && !out_stall;
    assign in_stall  = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr_t'(cfg_index))
                REG_MODE:      cfg_reg.mode           <= cfg_data[0];
                REG_TARGET:    cfg_reg.target         <= cfg_data[7:0];
                REG_BAND_LOW:  cfg_reg.band_low       <= $signed(cfg_data[15:0]);
                REG_BAND_HIGH: cfg_reg.band_high      <= $signed(cfg_data[15:0]);
                REG_WIDTH:     cfg_reg.slot_width     <= cfg_data[15:0];
                REG_SAMPLES:   cfg_reg.sample_count   <= cfg_data[SAMP_W-1:0];
                REG_POS_COUNT: cfg_reg.position_count <= cfg_data[CNT_W-1:0];
                REG_POSITIONS: cfg_reg.positions      <= cfg_data;
                default:       cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign pos_count = (cfg_reg.position_count > CNT_W'(NUM_POSITIONS))
                       ? CNT_W'(NUM_POSITIONS) : cfg_reg.position_count;

    bnc_prep u_prep (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .load              (accept),
        .node_index        (node_index),
        .neighbor_slot     (neighbor_slot),
        .node_particle     (node_particle),
        .neighbor_particle (neighbor_particle),
        .neighbor_valid    (neighbor_valid),
        .start_x           (start_x),
        .start_y           (start_y),
        .end_x             (end_x),
        .end_y             (end_y),
        .item_valid        (chain_valid[0]),
        .item              (chain_item[0])
    );

    for (genvar k = 0; k < NUM_POSITIONS; k++)
    begin : g_cell
        bnc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cfg         (cfg_reg),
            .xc          (cfg_reg.positions[k*COORD_WIDTH +: COORD_WIDTH]),
            .active      (CNT_W'(k) < pos_count),
            .in_valid_c  (chain_valid[k]),
            .in_item     (chain_item[k]),
            .out_valid_c (chain_valid[k+1]),
            .out_item    (chain_item[k+1])
        );
    end

    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (chain_valid[NUM_POSITIONS])
        begin
            out_valid_next = 1'b1;
        end
        if (deliver)
        begin
            out_valid_next = 1'b0;
            busy_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_valid[NUM_POSITIONS])
        begin
            out_index_reg <= chain_item[NUM_POSITIONS].node_index;
            out_slot_reg  <= chain_item[NUM_POSITIONS].neighbor_slot;
            out_hit_reg   <= chain_item[NUM_POSITIONS].hit;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_node_index    = out_index_reg;
    assign out_neighbor_slot = out_slot_reg;
    assign break_bond        = out_hit_reg;

    `ASSERT_SAME(a_out_implies_busy, out_valid_reg, busy_reg)
    `ASSERT_NEXT(a_accept_sets_busy, accept, busy_reg)
    `ASSERT_SAME(a_single_in_chain, 1'b1, $onehot0({chain_valid, out_valid_reg}))
    `ASSERT_SAME(a_chain_busy, chain_valid != '0, busy_reg)

endmodule

// ----- hdl/bnc_prep.sv -----
// front stage: particle gate, sample clamp and scaling by the sample count
// depends on bnc_pkg
module bnc_prep (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bnc_pkg::cfg_t                  cfg,
    input  logic                           load,
    input  logic [15:0]                    node_index,
    input  logic [5:0]                     neighbor_slot,
    input  logic [7:0]                     node_particle,
    input  logic [7:0]                     neighbor_particle,
    input  logic                           neighbor_valid,
    input  logic signed [15:0]             start_x,
    input  logic signed [15:0]             start_y,
    input  logic signed [15:0]             end_x,
    input  logic signed [15:0]             end_y,
    output logic                           item_valid,
    output bnc_pkg::item_t                 item
);
    import bnc_pkg::*;

    logic                     valid_reg;
    item_t                    item_reg;
    item_t                    item_next;
    logic [SAMP_W-1:0]        n_clamp;
    logic signed [SAMP_W:0]   n_s;

    always_comb
    begin
        n_clamp = (cfg.sample_count > SAMP_W'(MAX_SAMPLES)) ? SAMP_W'(MAX_SAMPLES)
                                                             : cfg.sample_count;
        n_s = $signed({1'b0, n_clamp});
        item_next               = '0;
        item_next.node_index    = node_index;
        item_next.neighbor_slot = neighbor_slot;
        item_next.gate          = neighbor_valid && (node_particle == cfg.target)
                                  && (neighbor_particle == cfg.target);
        item_next.n             = n_clamp;
        item_next.x0            = start_x;
        item_next.y0            = start_y;
        item_next.x1            = end_x;
        item_next.y1            = end_y;
        item_next.x0n           = SCALED_W'(start_x) * SCALED_W'(n_s);
        item_next.y0n           = SCALED_W'(start_y) * SCALED_W'(n_s);
        item_next.bln           = SCALED_W'(cfg.band_low) * SCALED_W'(n_s);
        item_next.bhn           = SCALED_W'(cfg.band_high) * SCALED_W'(n_s);
        item_next.hit           = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- hdl/bnc_cell.sv -----
// one notch position: line crossing and slot test, hit ored into the bond
// depends on bnc_pkg
module bnc_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bnc_pkg::cfg_t                 cfg,
    input  logic signed [15:0]            xc,
    input  logic                          active,
    input  logic                          in_valid_c,
    input  bnc_pkg::item_t                in_item,
    output logic                          out_valid_c,
    output bnc_pkg::item_t                out_item
);
    import bnc_pkg::*;

    logic                 valid_reg;
    item_t                item_reg;
    item_t                item_next;

    logic signed [16:0]   dx;
    logic signed [16:0]   dy;
    logic signed [16:0]   dabs;
    logic signed [16:0]   nn;
    logic signed [16:0]   a1;
    logic signed [16:0]   a2;
    logic signed [33:0]   p1;
    logic signed [33:0]   p2;
    logic signed [33:0]   p3;
    logic signed [34:0]   s1;
    logic signed [34:0]   s2;
    logic                 straddle;
    logic                 line_hit;
    logic signed [17:0]   xa2;
    logic signed [17:0]   xb2;
    logic signed [17:0]   ex0;
    logic signed [17:0]   ex1;
    logic                 yin0;
    logic                 yin1;
    logic                 end_hit;
    logic signed [SAMP_W:0] n_s;
    logic signed [SAMP_W:0] s_s;
    logic signed [23:0]   xa2n;
    logic signed [23:0]   xb2n;
    logic signed [22:0]   sdx;
    logic signed [22:0]   sdy;
    logic signed [25:0]   sx;
    logic signed [25:0]   sy;
    logic                 samp_hit;
    logic                 slot_hit;

    always_comb
    begin
        dx = 17'(in_item.x1) - 17'(in_item.x0);
        dy = 17'(in_item.y1) - 17'(in_item.y0);
        straddle = ((in_item.x0 < xc) && (in_item.x1 > xc))
                   || ((in_item.x0 > xc) && (in_item.x1 < xc));
        // orient so the denominator is positive
        if (dx[16])
        begin
            dabs = -dx;
            nn   = 17'(in_item.x0) - 17'(xc);
        end
        else
        begin
            dabs = dx;
            nn   = 17'(xc) - 17'(in_item.x0);
        end
        a1 = 17'(in_item.y0) - 17'(cfg.band_low);
        a2 = 17'(cfg.band_high) - 17'(in_item.y0);
        p1 = 34'(a1) * 34'(dabs);
        p2 = 34'(nn) * 34'(dy);
        p3 = 34'(a2) * 34'(dabs);
        s1 = 35'(p1) + 35'(p2);
        s2 = 35'(p3) - 35'(p2);
        line_hit = straddle && !s1[34] && !s2[34];

        xa2 = (18'(xc) <<< 1) - $signed({2'b00, cfg.slot_width});
        xb2 = (18'(xc) <<< 1) + $signed({2'b00, cfg.slot_width});
        ex0 = 18'(in_item.x0) <<< 1;
        ex1 = 18'(in_item.x1) <<< 1;
        yin0 = (in_item.y0 >= cfg.band_low) && (in_item.y0 <= cfg.band_high);
        yin1 = (in_item.y1 >= cfg.band_low) && (in_item.y1 <= cfg.band_high);
        end_hit = ((ex0 >= xa2) && (ex0 <= xb2) && yin0)
                  || ((ex1 >= xa2) && (ex1 <= xb2) && yin1);

        // evenly spaced samples, all checked side by side
        n_s  = $signed({1'b0, in_item.n});
        xa2n = 24'(xa2) * 24'(n_s);
        xb2n = 24'(xb2) * 24'(n_s);
        samp_hit = 1'b0;
        sdx = '0;
        sdy = '0;
        sx  = '0;
        sy  = '0;
        s_s = '0;
        for (int s = 0; s <= MAX_SAMPLES; s++)
        begin
            s_s = $signed({1'b0, SAMP_W'(s)});
            sdx = 23'(s_s) * 23'(dx);
            sdy = 23'(s_s) * 23'(dy);
            sx  = (26'(in_item.x0n) <<< 1) + (26'(sdx) <<< 1);
            sy  = 26'(in_item.y0n) + 26'(sdy);
            if ((in_item.n != '0) && (SAMP_W'(s) <= in_item.n)
                && (sx >= 26'(xa2n)) && (sx <= 26'(xb2n))
                && (sy >= 26'(in_item.bln)) && (sy <= 26'(in_item.bhn)))
            begin
                samp_hit = 1'b1;
            end
        end
        slot_hit = end_hit || samp_hit || line_hit;

        item_next     = in_item;
        item_next.hit = in_item.hit
                        || (active && in_item.gate && (cfg.mode ? slot_hit : line_hit));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_c)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid_c = valid_reg;
    assign out_item    = item_reg;

endmodule

// ----- sim/tb_bond_notch_crossing_test.sv -----
// testbench for bond_notch_crossing_test: directed and random bonds against a built-in predictor
// of the notch crossing rule, with bursty input, a stalling output and register writes when idle
// depends on bnc_pkg and the rtl of bond_notch_crossing_test
module tb_bond_notch_crossing_test;
    import bnc_pkg::*;

    typedef struct {
        logic [15:0]        node_index;
        logic [5:0]         slot;
        logic [7:0]         node_particle;
        logic [7:0]         neighbor_particle;
        logic               neighbor_valid;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
    } bond_t;

    typedef struct {
        logic [15:0] node_index;
        logic [5:0]  slot;
        logic        broken;
    } verdict_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        node_index;
    logic [5:0]         neighbor_slot;
    logic [7:0]         node_particle;
    logic [7:0]         neighbor_particle;
    logic               neighbor_valid;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic               out_valid;
    logic               out_stall;
    logic [15:0]        out_node_index;
    logic [5:0]         out_neighbor_slot;
    logic               break_bond;
    logic               cfg_valid;
    logic               cfg_ready;
    cfg_addr_t          cfg_index;
    logic [63:0]        cfg_data;

    cfg_t     shadow;
    verdict_t pending[$];
    int       error_count;
    int       bonds_sent;
    int       bonds_checked;
    int       breaks_seen;
    int       burst_left;
    bit       no_gaps;
    bit       stall_on;
    int       stall_phase;
    int       idle_cycles;

    bond_notch_crossing_test dut (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ---------------- predictor ----------------
    function automatic bit crosses_notch_line(longint x0, longint y0, longint x1, longint y1,
                                              longint xl);
        longint d;
        longint n;
        longint dy;
        longint blo;
        longint bhi;
        blo = longint'(shadow.band_low);
        bhi = longint'(shadow.band_high);
        if (!((x0 < xl && x1 > xl) || (x0 > xl && x1 < xl)))
            return 1'b0;
        d  = x1 - x0;
        n  = xl - x0;
        dy = y1 - y0;
        if (d < 0)
        begin
            d = -d;
            n = -n;
        end
        return ((y0 - blo) * d + n * dy >= 0) && ((bhi - y0) * d - n * dy >= 0);
    endfunction

    // point (x2/den, y/den) with x doubled
    function automatic bit point_in_slot(longint x2, longint y, longint den, longint xa2,
                                         longint xb2);
        return x2 >= xa2 * den && x2 <= xb2 * den &&
               y >= longint'(shadow.band_low) * den && y <= longint'(shadow.band_high) * den;
    endfunction

    function automatic bit enters_notch_slot(longint x0, longint y0, longint x1, longint y1,
                                             longint xc);
        longint w;
        longint xa2;
        longint xb2;
        longint n;
        w   = longint'({1'b0, shadow.slot_width});
        xa2 = 2 * xc - w;
        xb2 = 2 * xc + w;
        n   = longint'({1'b0, shadow.sample_count});
        if (n > MAX_SAMPLES)
            n = MAX_SAMPLES;
        if (point_in_slot(2 * x0, y0, 1, xa2, xb2) || point_in_slot(2 * x1, y1, 1, xa2, xb2))
            return 1'b1;
        for (longint s = 0; n > 0 && s <= n; s++)
            if (point_in_slot(2 * x0 * n + 2 * s * (x1 - x0), y0 * n + s * (y1 - y0), n,
                              xa2, xb2))
                return 1'b1;
        return crosses_notch_line(x0, y0, x1, y1, xc);
    endfunction

    function automatic bit bond_breaks(bond_t b);
        int     count;
        longint xp;
        count = shadow.position_count;
        if (count > NUM_POSITIONS)
            count = NUM_POSITIONS;
        if (!(b.neighbor_valid && b.node_particle == shadow.target &&
              b.neighbor_particle == shadow.target))
            return 1'b0;
        for (int p = 0; p < count; p++)
        begin
            xp = longint'($signed(shadow.positions[p*COORD_WIDTH +: COORD_WIDTH]));
            if (shadow.mode ? enters_notch_slot(b.sx, b.sy, b.ex, b.ey, xp)
                            : crosses_notch_line(b.sx, b.sy, b.ex, b.ey, xp))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // ---------------- drivers ----------------
    task automatic send_bond(bond_t b);
        int gap;
        gap = 0;
        if (!no_gaps)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        node_index        <= b.node_index;
        neighbor_slot     <= b.slot;
        node_particle     <= b.node_particle;
        neighbor_particle <= b.neighbor_particle;
        neighbor_valid    <= b.neighbor_valid;
        start_x           <= b.sx;
        start_y           <= b.sy;
        end_x             <= b.ex;
        end_y             <= b.ey;
        do @(posedge clk); while (in_stall);
        pending.push_back('{b.node_index, b.slot, bond_breaks(b)});
        bonds_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(cfg_addr_t idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MODE:      shadow.mode           = val[0];
            REG_TARGET:    shadow.target         = val[7:0];
            REG_BAND_LOW:  shadow.band_low       = val[15:0];
            REG_BAND_HIGH: shadow.band_high      = val[15:0];
            REG_WIDTH:     shadow.slot_width     = val[15:0];
            REG_SAMPLES:   shadow.sample_count   = val[4:0];
            REG_POS_COUNT: shadow.position_count = val[2:0];
            REG_POSITIONS: shadow.positions      = val;
            default: ;
        endcase
    endtask

    function automatic bond_t make_bond(logic [7:0] pa, logic [7:0] pb, logic nv,
                                        logic signed [15:0] sx, logic signed [15:0] sy,
                                        logic signed [15:0] ex, logic signed [15:0] ey);
        bond_t b;
        b.node_index        = $urandom;
        b.slot              = $urandom;
        b.node_particle     = pa;
        b.neighbor_particle = pb;
        b.neighbor_valid    = nv;
        b.sx = sx;
        b.sy = sy;
        b.ex = ex;
        b.ey = ey;
        return b;
    endfunction

    // coordinate near a notch position, wrapping at the 16-bit edge
    function automatic logic signed [15:0] near_notch();
        int c;
        c = $signed(shadow.positions[$urandom_range(0, 3)*16 +: 16]);
        return 16'(c + int'($urandom_range(0, 16'h1000)) - 16'h0800);
    endfunction

    function automatic bond_t random_bond();
        bond_t b;
        int    kind;
        kind = $urandom_range(0, 99);
        b = make_bond($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (kind < 80)
        begin
            b.node_particle     = shadow.target;
            b.neighbor_particle = ($urandom_range(0, 19) == 0) ? 8'($urandom) : shadow.target;
            b.neighbor_valid    = ($urandom_range(0, 9) != 0);
        end
        if (kind < 60)
        begin
            b.sx = near_notch();
            b.ex = near_notch();
            b.sy = 16'(int'($signed(shadow.band_low))
                       + int'($urandom_range(0, 16'h0c00)) - 16'h0600);
            b.ey = 16'(int'($signed(shadow.band_high))
                       + int'($urandom_range(0, 16'h0c00)) - 16'h0600);
            if ($urandom_range(0, 9) == 0)
                b.ex = b.sx;
        end
        return b;
    endfunction

    // ---------------- tests ----------------
    task automatic test_line_notches();
        write_reg(REG_MODE, 0);
        write_reg(REG_TARGET, 5);
        write_reg(REG_BAND_LOW, 64'hff00);
        write_reg(REG_BAND_HIGH, 64'h0100);
        write_reg(REG_POS_COUNT, 2);
        write_reg(REG_POSITIONS, 64'h1000_0000_ff00_0200);
        send_bond(make_bond(5, 5, 1, 16'h0100, 0, 16'h0300, 0));          // clean crossing
        send_bond(make_bond(5, 5, 1, 16'h0300, 16'h0080, 16'h0100, 0));   // reversed direction
        send_bond(make_bond(5, 5, 1, 16'h0200, 0, 16'h0300, 0));          // endpoint on the line
        send_bond(make_bond(5, 5, 1, 16'h0200, 16'hff00, 16'h0200, 16'h0100)); // vertical bond
        send_bond(make_bond(5, 5, 1, 16'h0100, 16'h0500, 16'h0300, 16'h0500)); // above band
        send_bond(make_bond(5, 5, 1, 16'h0100, 16'h0100, 16'h0300, 16'h0100)); // band edge
        send_bond(make_bond(5, 6, 1, 16'h0100, 0, 16'h0300, 0));          // particle mismatch
        send_bond(make_bond(4, 5, 1, 16'h0100, 0, 16'h0300, 0));
        send_bond(make_bond(5, 5, 0, 16'h0100, 0, 16'h0300, 0));          // invalid neighbor
        send_bond('{16'hffff, 6'h3f, 5, 5, 1, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
        send_bond('{16'h0000, 6'h00, 5, 5, 1, 16'sh7fff, 16'sh0000, 16'sh8000, 16'sh0000});
        wait_idle();
        // inverted band never matches
        write_reg(REG_BAND_LOW, 64'h0100);
        write_reg(REG_BAND_HIGH, 64'hff00);
        send_bond(make_bond(5, 5, 1, 16'h0100, 0, 16'h0300, 0));
        wait_idle();
        // position count beyond the table saturates, entry 3 is live
        write_reg(REG_BAND_LOW, 64'h8000);
        write_reg(REG_BAND_HIGH, 64'h7fff);
        write_reg(REG_POS_COUNT, 7);
        send_bond(make_bond(5, 5, 1, 16'h0f00, 0, 16'h1100, 0));
        wait_idle();
        write_reg(REG_POS_COUNT, 0);
        send_bond(make_bond(5, 5, 1, 16'h0100, 0, 16'h0300, 0));
        wait_idle();
    endtask

    task automatic test_slot_notches();
        write_reg(REG_MODE, 1);
        write_reg(REG_TARGET, 8'hff);
        write_reg(REG_BAND_LOW, 64'hff00);
        write_reg(REG_BAND_HIGH, 64'h0100);
        write_reg(REG_WIDTH, 64'h0200);
        write_reg(REG_SAMPLES, 0);
        write_reg(REG_POS_COUNT, 1);
        write_reg(REG_POSITIONS, 64'h0000_0000_0000_0000);
        send_bond(make_bond(8'hff, 8'hff, 1, 16'h0080, 0, 16'h0800, 0));   // endpoint inside
        send_bond(make_bond(8'hff, 8'hff, 1, 16'hfc00, 0, 16'h0400, 0));   // centre crossing
        send_bond(make_bond(8'hff, 8'hff, 1, 16'h0080, 16'hfb00, 16'h0080, 16'h0500));
        wait_idle();
        // vertical bond through the slot only found by samples
        write_reg(REG_SAMPLES, 2);
        send_bond(make_bond(8'hff, 8'hff, 1, 16'h0080, 16'hfb00, 16'h0080, 16'h0500));
        wait_idle();
        write_reg(REG_SAMPLES, 31);
        send_bond(make_bond(8'hff, 8'hff, 1, 16'h0080, 16'hfb00, 16'h0080, 16'h0500));
        wait_idle();
        write_reg(REG_WIDTH, 64'hffff);
        send_bond(make_bond(8'hff, 8'hff, 1, 16'h7000, 16'h0000, 16'h7fff, 16'h0000));
        send_bond(make_bond(8'hff, 8'hff, 1, 16'h7000, 16'h0200, 16'h7fff, 16'h0200));
        wait_idle();
    endtask

    task automatic test_random_phase(int items, bit extreme);
        write_reg(REG_MODE, $urandom_range(0, 1));
        write_reg(REG_TARGET, extreme ? ($urandom_range(0, 1) ? 8'hff : 8'h00) : $urandom);
        if (extreme)
        begin
            write_reg(REG_BAND_LOW, 64'h8000);
            write_reg(REG_BAND_HIGH, 64'h7fff);
            write_reg(REG_WIDTH, $urandom_range(0, 1) ? 64'hffff : 64'h0);
            write_reg(REG_SAMPLES, MAX_SAMPLES);
            write_reg(REG_POS_COUNT, NUM_POSITIONS);
        end
        else
        begin
            write_reg(REG_BAND_LOW, 16'(-int'($urandom_range(0, 16'h0800))));
            write_reg(REG_BAND_HIGH, ($urandom_range(0, 7) == 0) ? 16'hfe00
                                                                : $urandom_range(0, 16'h0800));
            write_reg(REG_WIDTH, $urandom_range(0, 16'h0400));
            write_reg(REG_SAMPLES, $urandom_range(0, 31));
            write_reg(REG_POS_COUNT, $urandom_range(0, 7));
        end
        write_reg(REG_POSITIONS, {16'($urandom_range(0, 16'h1000) - 16'h0800),
                                  16'($urandom), 16'($urandom_range(0, 16'h0400)),
                                  16'($urandom_range(0, 16'h0400) - 16'h0400)});
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (items) send_bond(random_bond());
        wait_idle();
    endtask

    // ---------------- output side ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_on    <= 1'b1;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase % 150 == 149)
                stall_on <= ~stall_on;
            // mostly short stalls, now and then a longer hold
            out_stall <= stall_on && (($urandom_range(0, 3) == 0) || (stall_phase % 37 < 5));
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending.size() == 0)
            begin
                $error("result transaction with nothing expected");
                error_count++;
            end
            else
            begin
                want = pending.pop_front();
                bonds_checked++;
                breaks_seen += break_bond;
                if (out_node_index !== want.node_index)
                begin
                    $error("out_node_index expected %h got %h", want.node_index, out_node_index);
                    error_count++;
                end
                if (out_neighbor_slot !== want.slot)
                begin
                    $error("out_neighbor_slot expected %h got %h", want.slot, out_neighbor_slot);
                    error_count++;
                end
                if (break_bond !== want.broken)
                begin
                    $error("break_bond expected %b got %b", want.broken, break_bond);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 3000)
        begin
            $display("timeout with %0d results outstanding", pending.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        node_index        = '0;
        neighbor_slot     = '0;
        node_particle     = '0;
        neighbor_particle = '0;
        neighbor_valid    = 1'b0;
        start_x           = '0;
        start_y           = '0;
        end_x             = '0;
        end_y             = '0;
        cfg_valid         = 1'b0;
        cfg_index         = REG_MODE;
        cfg_data          = '0;
        shadow            = '0;
        error_count       = 0;
        bonds_sent        = 0;
        bonds_checked     = 0;
        breaks_seen       = 0;
        burst_left        = 0;
        no_gaps           = 1'b0;
        idle_cycles       = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_line_notches();
        test_slot_notches();
        for (int ph = 0; ph < 6; ph++)
            test_random_phase(300, ph == 2 || ph == 5);

        $display("sent %0d bonds, checked %0d results, %0d broken bonds", bonds_sent,
                 bonds_checked, breaks_seen);
        $display("covered line and slot notches, band and count saturation, particle gating");
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/bnc_pkg.sv
hdl/bnc_prep.sv
hdl/bnc_cell.sv
hdl/bond_notch_crossing_test.sv
sim/tb_bond_notch_crossing_test.sv
